[rtl/complex_lag_correlation_moving_sum_assert.svh]
// Assertion macros for the lag-correlation moving sum.
// Included by the top level; no other dependencies.
`ifndef COMPLEX_LAG_CORRELATION_MOVING_SUM_ASSERT_SVH
`define COMPLEX_LAG_CORRELATION_MOVING_SUM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CLCMS_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CLCMS_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

[rtl/clcms_pkg.sv]
// Shared width helpers for the lag-correlation moving sum.
// No dependencies.
`default_nettype none

package clcms_pkg;

   // conjugate product of two complex samples needs one bit beyond 2*n
   function automatic int prod_bits(input int sample_bits);
      return 2 * sample_bits + 1;
   endfunction

   // window sum grows by log2 of the window length
   function automatic int corr_bits(input int sample_bits, input int window_len);
      return prod_bits(sample_bits) + $clog2(window_len);
   endfunction

endpackage

`default_nettype wire

[rtl/clcms_if.sv]
// Valid/ready channel interfaces for the sample input and the correlation output.
// No dependencies.
`default_nettype none

interface clcms_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_real;
   logic signed [SAMPLE_BITS-1:0] sample_imag;
   logic signed [SAMPLE_BITS-1:0] lagged_real;
   logic signed [SAMPLE_BITS-1:0] lagged_imag;

   modport source (output valid, sample_real, sample_imag, lagged_real, lagged_imag,
                   input ready);
   modport sink   (input valid, sample_real, sample_imag, lagged_real, lagged_imag,
                   output ready);
endinterface

interface clcms_rsp_if #(parameter int CORR_BITS = 37);
   logic                        valid;
   logic                        ready;
   logic signed [CORR_BITS-1:0] corr_real;
   logic signed [CORR_BITS-1:0] corr_imag;

   modport source (output valid, corr_real, corr_imag, input ready);
   modport sink   (input valid, corr_real, corr_imag, output ready);
endinterface

`default_nettype wire

[rtl/clcms_conj_mult.sv]
// Registered complex multiply by the conjugate: p = s * conj(l).
// Depends on clcms_pkg.
`default_nettype none

module clcms_conj_mult
   import clcms_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  enable,
   input  wire logic signed [SAMPLE_BITS-1:0]         sample_real,
   input  wire logic signed [SAMPLE_BITS-1:0]         sample_imag,
   input  wire logic signed [SAMPLE_BITS-1:0]         lagged_real,
   input  wire logic signed [SAMPLE_BITS-1:0]         lagged_imag,
   output logic signed [prod_bits(SAMPLE_BITS)-1:0]   prod_real,
   output logic signed [prod_bits(SAMPLE_BITS)-1:0]   prod_imag
);

   localparam int MW = 2 * SAMPLE_BITS;
   localparam int PB = prod_bits(SAMPLE_BITS);

   logic signed [MW-1:0] ac, bd, bc, ad;
   logic signed [PB-1:0] prod_real_in, prod_imag_in;
   logic signed [PB-1:0] prod_real_ff, prod_imag_ff;

   always_comb begin
      ac = MW'(sample_real) * MW'(lagged_real);
      bd = MW'(sample_imag) * MW'(lagged_imag);
      bc = MW'(sample_imag) * MW'(lagged_real);
      ad = MW'(sample_real) * MW'(lagged_imag);
      prod_real_in = {ac[MW-1], ac} + {bd[MW-1], bd};
      prod_imag_in = {bc[MW-1], bc} - {ad[MW-1], ad};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_real_ff <= prod_real_in;
         prod_imag_ff <= prod_imag_in;
      end
   end

   assign prod_real = prod_real_ff;
   assign prod_imag = prod_imag_ff;

endmodule

`default_nettype wire

[rtl/clcms_prod_ram.sv]
// Product delay line: one write and one registered read port per cycle.
// Per-entry valid bits make unwritten entries read as zero after reset.
`default_nettype none

module clcms_prod_ram
   import clcms_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_BITS  = 66
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [DATA_BITS-1:0]       rd_data,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [DATA_BITS-1:0]       wr_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]     entry_valid_ff;
   logic [DATA_BITS-1:0] rd_raw_ff;
   logic                 rd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_hit_ff      <= 1'b0;
      end else begin
         if (wr_en) begin
            entry_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_hit_ff <= entry_valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_hit_ff ? rd_raw_ff : '0;

endmodule

`default_nettype wire

[rtl/complex_lag_correlation_moving_sum.sv]
// Lag-correlation moving sum over a window of conjugate products.
// Usage:
//   req_chan carries a sample and the sample one lag earlier; rsp_chan carries
//   the complex sum of the last WINDOW_LEN conjugate products, this one included.
//   Both are valid/ready; an item moves at an edge where valid and ready are high.
// Pipeline: an accepted item passes the input register, the multiply stage with
//   product-line read, and the sum/output register before its result is valid.
// Throughput: one item per cycle while rsp_chan takes results, bounded by the
//   single read and single write port of the product-line memory.
// Reset: clears the running sums, the line write position, the entry valid
//   bits (old slots read as zero) and all stage valid flags; no clearing pass.
// Stall: while rsp_chan.ready is low the result holds; the input and multiply
//   stages fill, so up to two more items are taken before req_chan.ready drops.
// Depends on clcms_pkg, clcms_if, clcms_conj_mult, clcms_prod_ram and the assertion macros header.
`default_nettype none

`include "complex_lag_correlation_moving_sum_assert.svh"

module complex_lag_correlation_moving_sum
   import clcms_pkg::*;
#(
   parameter int WINDOW_LEN  = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   clcms_req_if.sink   req_chan,
   clcms_rsp_if.source rsp_chan
);

   localparam int PB = prod_bits(SAMPLE_BITS);
   localparam int CB = corr_bits(SAMPLE_BITS, WINDOW_LEN);
   localparam int AW = $clog2(WINDOW_LEN);
   localparam int GB = CB - PB;

   // handshake and stage control
   logic req_fire, a_move, b_move, b_ready, c_ready;

   // input stage
   logic                          a_valid_ff, a_valid_in;
   logic signed [SAMPLE_BITS-1:0] a_sr_ff, a_si_ff, a_lr_ff, a_li_ff;
   logic [AW-1:0]                 a_pos_ff;
   logic [AW-1:0]                 pos_ff, pos_in;

   // product stage
   logic                 b_valid_ff, b_valid_in;
   logic [AW-1:0]        b_pos_ff;
   logic signed [PB-1:0] prod_real, prod_imag;
   logic [2*PB-1:0]      old_word;
   logic signed [PB-1:0] leave_real, leave_imag;

   // sum / output stage
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [CB-1:0] sum_real_ff, sum_real_in;
   logic signed [CB-1:0] sum_imag_ff, sum_imag_in;

   assign c_ready  = !rsp_valid_ff || rsp_chan.ready;
   assign b_move   = b_valid_ff && c_ready;
   assign b_ready  = !b_valid_ff || b_move;
   assign a_move   = a_valid_ff && b_ready;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !a_valid_ff || a_move;

   always_comb begin
      pos_in = pos_ff;
      if (req_fire) begin
         pos_in = (pos_ff == AW'(WINDOW_LEN - 1)) ? '0 : pos_ff + 1'b1;
      end
      a_valid_in   = req_fire ? 1'b1 : (a_move ? 1'b0 : a_valid_ff);
      b_valid_in   = a_move ? 1'b1 : (b_move ? 1'b0 : b_valid_ff);
      rsp_valid_in = b_move ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

      leave_real = old_word[2*PB-1:PB];
      leave_imag = old_word[PB-1:0];
      sum_real_in = sum_real_ff;
      sum_imag_in = sum_imag_ff;
      if (b_move) begin
         // add the new product, drop the one leaving the window
         sum_real_in = sum_real_ff + {{GB{prod_real[PB-1]}}, prod_real}
                                   - {{GB{leave_real[PB-1]}}, leave_real};
         sum_imag_in = sum_imag_ff + {{GB{prod_imag[PB-1]}}, prod_imag}
                                   - {{GB{leave_imag[PB-1]}}, leave_imag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_real_ff  <= '0;
         sum_imag_ff  <= '0;
      end else begin
         pos_ff       <= pos_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_real_ff  <= sum_real_in;
         sum_imag_ff  <= sum_imag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_sr_ff  <= req_chan.sample_real;
         a_si_ff  <= req_chan.sample_imag;
         a_lr_ff  <= req_chan.lagged_real;
         a_li_ff  <= req_chan.lagged_imag;
         a_pos_ff <= pos_ff;
      end
      if (a_move) begin
         b_pos_ff <= a_pos_ff;
      end
   end

   clcms_conj_mult #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mult (
      .clock       (clock),
      .enable      (a_move),
      .sample_real (a_sr_ff),
      .sample_imag (a_si_ff),
      .lagged_real (a_lr_ff),
      .lagged_imag (a_li_ff),
      .prod_real   (prod_real),
      .prod_imag   (prod_imag)
   );

   // slot read as the item enters the product stage, rewritten as it leaves
   clcms_prod_ram #(
      .DEPTH     (WINDOW_LEN),
      .DATA_BITS (2 * PB)
   ) u_line (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (a_move),
      .rd_addr (a_pos_ff),
      .rd_data (old_word),
      .wr_en   (b_move),
      .wr_addr (b_pos_ff),
      .wr_data ({prod_real, prod_imag})
   );

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.corr_real = sum_real_ff;
   assign rsp_chan.corr_imag = sum_imag_ff;

   `CLCMS_ASSERT_NOW(a_no_slot_clash, clock, reset, a_move && b_move,
      a_pos_ff != b_pos_ff, "product line read and write hit the same slot")
   `CLCMS_ASSERT_NEXT(a_sum_holds, clock, reset, !b_move,
      $stable(sum_real_ff) && $stable(sum_imag_ff), "window sum changed without a product")
   `CLCMS_ASSERT_NEXT(a_stalled_product_kept, clock, reset, b_valid_ff && !c_ready,
      b_valid_ff && $stable(b_pos_ff), "product stage lost a stalled item")
   `CLCMS_ASSERT_NEXT(a_pos_steps, clock, reset, req_fire,
      a_valid_ff && a_pos_ff == $past(pos_ff), "input stage did not capture the line position")

endmodule

`default_nettype wire

[sim/complex_lag_correlation_moving_sum_test.sv]
// Self-checking testbench for the lag-correlation moving sum: drives sample pairs,
// keeps its own 16-deep conjugate-product window and checks every correlation item.
// Depends on rtl/clcms_pkg.sv, rtl/clcms_if.sv and the top level.
`default_nettype none

module complex_lag_correlation_moving_sum_test
   import clcms_pkg::*;
();

   localparam int WINDOW   = 16;
   localparam int SAMPLE_W = 16;
   localparam int PROD_W   = prod_bits(SAMPLE_W);
   localparam int CORR_W   = corr_bits(SAMPLE_W, WINDOW);
   localparam int RANDOM_ITEMS = 450;
   localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_real;
      logic signed [SAMPLE_W-1:0] sample_imag;
      logic signed [SAMPLE_W-1:0] lagged_real;
      logic signed [SAMPLE_W-1:0] lagged_imag;
   } sample_pair_type;

   typedef struct packed {
      logic signed [CORR_W-1:0] corr_real;
      logic signed [CORR_W-1:0] corr_imag;
   } corr_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   clcms_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_chan ();
   clcms_rsp_if #(.CORR_BITS(CORR_W))     rsp_chan ();

   complex_lag_correlation_moving_sum #(
      .WINDOW_LEN (WINDOW),
      .SAMPLE_BITS(SAMPLE_W)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #5 clock = ~clock;

   sample_pair_type sample_backlog[$];
   corr_type        expected_corr[$];

   // window model: product line, running sums, write slot
   logic signed [PROD_W-1:0] line_real [WINDOW];
   logic signed [PROD_W-1:0] line_imag [WINDOW];
   longint                   window_real = 0;
   longint                   window_imag = 0;
   int                       line_slot   = 0;

   int unsigned items_taken  = 0;
   int unsigned corr_checked = 0;
   int unsigned fail_count   = 0;

   initial begin
      for (int i = 0; i < WINDOW; i++) begin
         line_real[i] = '0;
         line_imag[i] = '0;
      end
   end

   function automatic void advance_window_sum(input sample_pair_type s);
      longint   prod_real;
      longint   prod_imag;
      corr_type due;
      prod_real = longint'(s.sample_real) * longint'(s.lagged_real)
                + longint'(s.sample_imag) * longint'(s.lagged_imag);
      prod_imag = longint'(s.sample_imag) * longint'(s.lagged_real)
                - longint'(s.sample_real) * longint'(s.lagged_imag);
      // oldest product leaves as the new one enters
      window_real = window_real + prod_real - longint'(line_real[line_slot]);
      window_imag = window_imag + prod_imag - longint'(line_imag[line_slot]);
      line_real[line_slot] = prod_real[PROD_W-1:0];
      line_imag[line_slot] = prod_imag[PROD_W-1:0];
      line_slot = (line_slot + 1) % WINDOW;
      due.corr_real = window_real[CORR_W-1:0];
      due.corr_imag = window_imag[CORR_W-1:0];
      expected_corr.push_back(due);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return S_MIN;
         1: return S_MAX;
         2: return '0;
         3: return '1;
         4: return SAMPLE_W'($signed($urandom_range(0, 16)) - 8);
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   // sender: bursts of random length, random gaps between them
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin
      sample_pair_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            advance_window_sum('{req_chan.sample_real, req_chan.sample_imag,
                                 req_chan.lagged_real, req_chan.lagged_imag});
            items_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (sample_backlog.size() > 0) begin
               nxt = sample_backlog.pop_front();
               req_chan.sample_real <= nxt.sample_real;
               req_chan.sample_imag <= nxt.sample_imag;
               req_chan.lagged_real <= nxt.lagged_real;
               req_chan.lagged_imag <= nxt.lagged_imag;
               req_chan.valid       <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern switches mode at random intervals
   int unsigned ready_mode = 0;
   int unsigned mode_left  = 0;
   int unsigned stall_tick = 0;

   always @(posedge clock) begin
      corr_type due;
      logic     next_ready;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_corr.size() == 0) begin
               $error("unexpected corr item: real %0d imag %0d",
                      rsp_chan.corr_real, rsp_chan.corr_imag);
               fail_count++;
            end else begin
               due = expected_corr.pop_front();
               corr_checked++;
               if (rsp_chan.corr_real !== due.corr_real) begin
                  $error("corr_real: expected %0d, got %0d",
                         due.corr_real, rsp_chan.corr_real);
                  fail_count++;
               end
               if (rsp_chan.corr_imag !== due.corr_imag) begin
                  $error("corr_imag: expected %0d, got %0d",
                         due.corr_imag, rsp_chan.corr_imag);
                  fail_count++;
               end
            end
         end
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 80);
            stall_tick = 0;
         end
         case (ready_mode)
            0: next_ready = 1'b1;
            1: next_ready = ($urandom_range(0, 3) != 0);
            2: next_ready = ((stall_tick % 7) >= 3);
            default: next_ready = ((stall_tick % 16) >= 12);
         endcase
         mode_left--;
         stall_tick++;
         rsp_chan.ready <= next_ready;
      end
   end

   initial begin
      sample_pair_type s;
      int unsigned     queued;
      int unsigned     run_len;
      req_chan.valid       = 1'b0;
      req_chan.sample_real = '0;
      req_chan.sample_imag = '0;
      req_chan.lagged_real = '0;
      req_chan.lagged_imag = '0;
      rsp_chan.ready       = 1'b0;

      // start of stream: partial window over a few small products
      sample_backlog.push_back('{16'sd3, -16'sd2, 16'sd5, 16'sd7});
      sample_backlog.push_back('{-16'sd1, 16'sd1, -16'sd1, 16'sd1});
      sample_backlog.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
      // a full window of most-negative inputs drives the real sum to +2^35
      repeat (WINDOW) sample_backlog.push_back('{S_MIN, S_MIN, S_MIN, S_MIN});
      sample_backlog.push_back('{S_MIN, S_MIN, S_MAX, S_MAX});
      sample_backlog.push_back('{S_MIN, S_MIN, S_MIN, S_MAX});
      sample_backlog.push_back('{S_MIN, S_MAX, S_MIN, S_MIN});
      sample_backlog.push_back('{S_MAX, S_MAX, S_MAX, S_MAX});
      sample_backlog.push_back('{S_MAX, S_MIN, S_MIN, S_MAX});

      queued = 0;
      while (queued < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 2) begin
            // sustained extreme run pushes the window sums to their limits
            case ($urandom_range(0, 3))
               0: s = '{S_MIN, S_MIN, S_MIN, S_MIN};
               1: s = '{S_MIN, S_MIN, S_MAX, S_MAX};
               2: s = '{S_MIN, S_MIN, S_MIN, S_MAX};
               default: s = '{S_MIN, S_MAX, S_MIN, S_MIN};
            endcase
            run_len = $urandom_range(WINDOW, WINDOW + 4);
            repeat (run_len) sample_backlog.push_back(s);
            queued += run_len;
         end else begin
            s.sample_real = pick_sample();
            s.sample_imag = pick_sample();
            s.lagged_real = pick_sample();
            s.lagged_imag = pick_sample();
            sample_backlog.push_back(s);
            queued++;
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (sample_backlog.size() != 0 || req_chan.valid || expected_corr.size() != 0);
      repeat (8) @(negedge clock);

      $display("Drove %0d sample pairs, incl. full-scale windows and start-of-stream fill;",
               items_taken);
      $display("checked %0d correlation items under random bursts and output stalls.",
               corr_checked);
      if (fail_count == 0 && expected_corr.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
